// ===== src/pcba_pkg.sv =====
// Package for the per-thread cached block allocator.
// Field widths, default sizes, operation codes and the controller/datapath structs.
// No dependencies.
package pcba_pkg;

  localparam int THREADS_DEF = 8;
  localparam int TARGET_DEF  = 3;
  localparam int BLOCKS_DEF  = 64;

  localparam int OP_W  = 1;
  localparam int THR_W = 3;
  localparam int BLK_W = 6;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic latch;       // take the input word, clear the result
    logic idx_clr;     // slot index to 0 (refill)
    logic idx_top;     // slot index to top of local stack (spill)
    logic glob_rd;     // read global top, pop global
    logic refill_wr;   // write global data into local slot idx, count = idx + 1
    logic pop_rd;      // read local top, pop local
    logic spill_wr;    // push local data onto global, step idx down
    logic set_target;  // local count = TARGET after a spill
    logic push;        // write freed block onto local top
    logic res_ovf;     // flag overflow in result
    logic res_grant;   // result takes the popped block
    logic load_out;    // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_free;
    logic thr_bad;
    logic lcnt_zero;
    logic lcnt_full;
    logic gcnt_zero;
    logic gspace_short;
    logic idx_last;    // refill slot index at TARGET-1
    logic idx_target;  // spill slot index at TARGET
    logic out_free;
  } sts_t;

endpackage

// ===== src/pcba_ctrl.sv =====
// Controller state machine of the block allocator.
// Sequences refill, spill, push and pop steps; depends on pcba_pkg.
module pcba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pcba_pkg::sts_t sts,
  output pcba_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECIDE    = 4'd1;
  localparam logic [3:0] S_REFILL_RD = 4'd2;
  localparam logic [3:0] S_REFILL_WR = 4'd3;
  localparam logic [3:0] S_POP_RD    = 4'd4;
  localparam logic [3:0] S_POP_WAIT  = 4'd5;
  localparam logic [3:0] S_SPILL_RD  = 4'd6;
  localparam logic [3:0] S_SPILL_WR  = 4'd7;
  localparam logic [3:0] S_PUSH      = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.thr_bad) begin
          state_nxt = S_DONE;
        end else if (!sts.op_free) begin
          if (!sts.lcnt_zero) begin
            state_nxt = S_POP_RD;
          end else if (sts.gcnt_zero) begin
            state_nxt = S_DONE;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_REFILL_RD;
          end
        end else begin
          if (!sts.lcnt_full) begin
            state_nxt = S_PUSH;
          end else if (sts.gspace_short) begin
            cmd.res_ovf = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            cmd.idx_top = 1'b1;
            state_nxt   = S_SPILL_RD;
          end
        end
      end
      S_REFILL_RD: begin
        cmd.glob_rd = 1'b1;
        state_nxt   = S_REFILL_WR;
      end
      S_REFILL_WR: begin
        cmd.refill_wr = 1'b1;
        // gcnt already reflects the pop just done
        if (sts.idx_last || sts.gcnt_zero) begin
          state_nxt = S_POP_RD;
        end else begin
          state_nxt = S_REFILL_RD;
        end
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        cmd.res_grant = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SPILL_RD: begin
        state_nxt = S_SPILL_WR;
      end
      S_SPILL_WR: begin
        cmd.spill_wr = 1'b1;
        if (sts.idx_target) begin
          cmd.set_target = 1'b1;
          state_nxt      = S_PUSH;
        end else begin
          state_nxt = S_SPILL_RD;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/pcba_dpath.sv =====
// Datapath of the block allocator: local and global stack memories, fill counts,
// result and output registers. Depends on pcba_pkg.
module pcba_dpath #(
  parameter int THREADS = pcba_pkg::THREADS_DEF,
  parameter int TARGET  = pcba_pkg::TARGET_DEF,
  parameter int BLOCKS  = pcba_pkg::BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pcba_pkg::OP_W-1:0]   in_op,
  input  logic [pcba_pkg::THR_W-1:0]  in_thread,
  input  logic [pcba_pkg::BLK_W-1:0]  in_block,
  output logic [pcba_pkg::BLK_W-1:0]  out_granted_block,
  output logic                        out_granted,
  output logic                        out_overflow,
  output logic                        out_valid,
  input  logic                        out_stall,
  input  pcba_pkg::cmd_t              cmd,
  output pcba_pkg::sts_t              sts
);

  localparam int LDEPTH = 2 * TARGET;
  localparam int LWORDS = THREADS * LDEPTH;
  localparam int TW     = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int SW     = $clog2(LDEPTH);
  localparam int LCW    = $clog2(LDEPTH + 1);
  localparam int LAW    = $clog2(LWORDS);
  localparam int GCW    = $clog2(BLOCKS + 1);
  localparam int GAW    = $clog2(BLOCKS);
  localparam int BW     = pcba_pkg::BLK_W;

  logic [pcba_pkg::OP_W-1:0]  op_r;
  logic [pcba_pkg::THR_W-1:0] thr_r;
  logic [BW-1:0]              blk_r;
  logic [LCW-1:0]             lcnt_r [THREADS];
  logic [GCW-1:0]             gcnt_r;
  logic [GCW-1:0]             gcnt_nxt;
  logic [SW-1:0]              idx_r;
  logic [SW-1:0]              idx_nxt;
  logic [BW-1:0]              res_block_r;
  logic                       res_granted_r;
  logic                       res_ovf_r;
  logic [BW-1:0]              out_block_r;
  logic                       out_granted_r;
  logic                       out_ovf_r;
  logic                       out_valid_r;

  logic [BW-1:0] loc_mem  [LWORDS];
  logic [BW-1:0] glob_mem [BLOCKS];
  logic [BW-1:0] loc_rdata_r;
  logic [BW-1:0] glob_rdata_r;

  logic [TW+pcba_pkg::THR_W-1:0] thr_ext;
  logic [TW-1:0]                 thr_idx;
  logic [LCW-1:0]                lcnt_cur;
  logic                          lcnt_we;
  logic [LCW-1:0]                lcnt_wval;
  logic [SW-1:0]                 rd_slot;
  logic [SW-1:0]                 wr_slot;
  logic [LAW-1:0]                loc_raddr;
  logic [LAW-1:0]                loc_waddr;
  logic                          loc_we;
  logic [BW-1:0]                 loc_wdata;
  logic [GAW-1:0]                glob_raddr;
  logic [GAW-1:0]                glob_waddr;

  assign thr_ext  = {{TW{1'b0}}, thr_r};
  assign thr_idx  = thr_ext[TW-1:0];
  assign lcnt_cur = lcnt_r[thr_idx];

  // slot selection: pop reads the top, spill reads idx; push writes the top, refill idx
  assign rd_slot = cmd.pop_rd ? SW'(lcnt_cur - LCW'(1)) : idx_r;
  assign wr_slot = cmd.push ? lcnt_cur[SW-1:0] : idx_r;

  assign loc_raddr = LAW'(32'(thr_idx) * LDEPTH + 32'(rd_slot));
  assign loc_waddr = LAW'(32'(thr_idx) * LDEPTH + 32'(wr_slot));
  assign loc_we    = cmd.push || cmd.refill_wr;
  assign loc_wdata = cmd.push ? blk_r : glob_rdata_r;

  assign glob_raddr = GAW'(gcnt_r - GCW'(1));
  assign glob_waddr = gcnt_r[GAW-1:0];

  always_comb begin
    lcnt_we   = 1'b1;
    lcnt_wval = lcnt_cur;
    if (cmd.refill_wr) begin
      lcnt_wval = LCW'(idx_r) + LCW'(1);
    end else if (cmd.pop_rd) begin
      lcnt_wval = lcnt_cur - LCW'(1);
    end else if (cmd.set_target) begin
      lcnt_wval = LCW'(TARGET);
    end else if (cmd.push) begin
      lcnt_wval = lcnt_cur + LCW'(1);
    end else begin
      lcnt_we = 1'b0;
    end
  end

  always_comb begin
    gcnt_nxt = gcnt_r;
    if (cmd.glob_rd) begin
      gcnt_nxt = gcnt_r - GCW'(1);
    end else if (cmd.spill_wr) begin
      gcnt_nxt = gcnt_r + GCW'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_top) begin
      idx_nxt = SW'(LDEPTH - 1);
    end else if (cmd.refill_wr) begin
      idx_nxt = idx_r + SW'(1);
    end else if (cmd.spill_wr) begin
      idx_nxt = idx_r - SW'(1);
    end
  end

  always_comb begin
    sts.op_free      = (op_r == pcba_pkg::OP_FREE);
    sts.thr_bad      = (32'(thr_r) >= THREADS);
    sts.lcnt_zero    = (lcnt_cur == '0);
    sts.lcnt_full    = (lcnt_cur == LCW'(LDEPTH));
    sts.gcnt_zero    = (gcnt_r == '0);
    sts.gspace_short = ((32'(gcnt_r) + TARGET) > BLOCKS);
    sts.idx_last     = (idx_r == SW'(TARGET - 1));
    sts.idx_target   = (idx_r == SW'(TARGET));
    sts.out_free     = !out_valid_r || !out_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < THREADS; i++) begin
        lcnt_r[i] <= '0;
      end
      gcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (lcnt_we) begin
        lcnt_r[thr_idx] <= lcnt_wval;
      end
      gcnt_r <= gcnt_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch) begin
      op_r          <= in_op;
      thr_r         <= in_thread;
      blk_r         <= in_block;
      res_block_r   <= '0;
      res_granted_r <= 1'b0;
      res_ovf_r     <= 1'b0;
    end
    if (cmd.res_ovf) begin
      res_ovf_r <= 1'b1;
    end
    if (cmd.res_grant) begin
      res_block_r   <= loc_rdata_r;
      res_granted_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_block_r   <= res_block_r;
      out_granted_r <= res_granted_r;
      out_ovf_r     <= res_ovf_r;
    end
  end

  // local stack memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (loc_we) begin
      loc_mem[loc_waddr] <= loc_wdata;
    end
    loc_rdata_r <= loc_mem[loc_raddr];
  end

  // global stack memory
  always_ff @(posedge clk) begin
    if (cmd.spill_wr) begin
      glob_mem[glob_waddr] <= loc_rdata_r;
    end
    glob_rdata_r <= glob_mem[glob_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = out_block_r;
  assign out_granted       = out_granted_r;
  assign out_overflow      = out_ovf_r;

endmodule

// ===== src/per_thread_cached_block_allocator.sv =====
// A plain free passes decide, push and done; a failed request (no grant or overflow) goes
// from decide to done; a pop from a non-empty local stack passes pop read and pop wait.
// Each block moved by a refill or spill adds a read and a write state (registered memory
// read, then write). A stalled result word holds the block in its final state.
// Throughput: one word at a time, next accepted the cycle after the result is registered.
// Reset: synchronous, active low; all stacks empty, stack memory contents left as is.
// Top level of the allocator; depends on pcba_pkg, pcba_ctrl and pcba_dpath.
module per_thread_cached_block_allocator #(
  parameter int THREADS = pcba_pkg::THREADS_DEF,
  parameter int TARGET  = pcba_pkg::TARGET_DEF,
  parameter int BLOCKS  = pcba_pkg::BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pcba_pkg::OP_W-1:0]   in_op,
  input  logic [pcba_pkg::THR_W-1:0]  in_thread,
  input  logic [pcba_pkg::BLK_W-1:0]  in_block,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pcba_pkg::BLK_W-1:0]  out_granted_block,
  output logic                        out_granted,
  output logic                        out_overflow
);

  pcba_pkg::cmd_t cmd;
  pcba_pkg::sts_t sts;

  pcba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcba_dpath #(
    .THREADS (THREADS),
    .TARGET  (TARGET),
    .BLOCKS  (BLOCKS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_op),
    .in_thread         (in_thread),
    .in_block          (in_block),
    .out_granted_block (out_granted_block),
    .out_granted       (out_granted),
    .out_overflow      (out_overflow),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// ===== bench/pcba_alloc_checker.sv =====
// Checker for the per-thread cached block allocator: watches both channels, keeps its
// own copy of the local and global stacks, predicts every result word and compares.
// Depends on pcba_pkg.
module pcba_alloc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [pcba_pkg::OP_W-1:0]   in_op,
  input  logic [pcba_pkg::THR_W-1:0]  in_thread,
  input  logic [pcba_pkg::BLK_W-1:0]  in_block,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [pcba_pkg::BLK_W-1:0]  out_granted_block,
  input  logic                        out_granted,
  input  logic                        out_overflow,
  output int                          fail_count,
  output int                          pending
);
  import pcba_pkg::*;

  localparam int THREADS = THREADS_DEF;
  localparam int TARGET  = TARGET_DEF;
  localparam int BLOCKS  = BLOCKS_DEF;
  localparam int CACHE_DEPTH = 2 * TARGET;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic             granted;
    logic             ovf;
  } grant_word_t;

  logic [BLK_W-1:0] cache_mem [THREADS][CACHE_DEPTH];
  int               cache_fill [THREADS];
  logic [BLK_W-1:0] pool_mem [BLOCKS];
  int               pool_fill;

  grant_word_t      expected_words [$];
  int               n_fail = 0;

  function automatic grant_word_t serve_request(input logic [OP_W-1:0] op,
                                                input logic [THR_W-1:0] thr,
                                                input logic [BLK_W-1:0] blk);
    grant_word_t r;
    int          t;
    int          i;
    r = '0;
    t = int'(thr);
    if (t >= THREADS) return r;
    if (op == OP_ALLOC) begin
      if (cache_fill[t] == 0) begin
        // refill into slots 0 upward from the global top
        i = 0;
        while (i < TARGET && pool_fill > 0) begin
          pool_fill--;
          cache_mem[t][i] = pool_mem[pool_fill];
          i++;
        end
        cache_fill[t] = i;
      end
      if (cache_fill[t] > 0) begin
        cache_fill[t]--;
        r.blk     = cache_mem[t][cache_fill[t]];
        r.granted = 1'b1;
      end
    end else begin
      if (cache_fill[t] >= CACHE_DEPTH) begin
        // no room for the spill: the whole free is dropped
        if (pool_fill + (CACHE_DEPTH - TARGET) > BLOCKS) begin
          r.ovf = 1'b1;
          return r;
        end
        for (i = CACHE_DEPTH; i > TARGET; i--) begin
          pool_mem[pool_fill] = cache_mem[t][i-1];
          pool_fill++;
        end
        cache_fill[t] = TARGET;
      end
      cache_mem[t][cache_fill[t]] = blk;
      cache_fill[t]++;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    grant_word_t want;
    if (!rst_n) begin
      for (int t = 0; t < THREADS; t++) cache_fill[t] = 0;
      pool_fill = 0;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_words.push_back(serve_request(in_op, in_thread, in_block));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          n_fail++;
          $display("%0t: result word with nothing outstanding: block %0d granted %0b ovf %0b",
                   $time, out_granted_block, out_granted, out_overflow);
        end else begin
          want = expected_words.pop_front();
          if (out_granted_block !== want.blk) begin
            n_fail++;
            $display("%0t: granted_block expected %0d, got %0d",
                     $time, want.blk, out_granted_block);
          end
          if (out_granted !== want.granted) begin
            n_fail++;
            $display("%0t: granted expected %0b, got %0b", $time, want.granted, out_granted);
          end
          if (out_overflow !== want.ovf) begin
            n_fail++;
            $display("%0t: overflow expected %0b, got %0b", $time, want.ovf, out_overflow);
          end
        end
      end
    end
    fail_count <= n_fail;
    pending    <= expected_words.size();
  end

endmodule

// ===== bench/tb_per_thread_cached_block_allocator.sv =====
// Top of the allocator testbench: clock, reset, request and result-side stimulus.
// Prediction and comparison sit in pcba_alloc_checker; depends on pcba_pkg and the block.
module tb_per_thread_cached_block_allocator;
  import pcba_pkg::*;

  typedef enum int { MIX_ALLOC, MIX_FREE, MIX_EVEN } req_mix_t;

  localparam int RANDOM_WORDS = 1500;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [OP_W-1:0]  in_op;
  logic [THR_W-1:0] in_thread;
  logic [BLK_W-1:0] in_block;
  logic             out_valid;
  logic             out_stall;
  logic [BLK_W-1:0] out_granted_block;
  logic             out_granted;
  logic             out_overflow;
  int               fail_count;
  int               pending;
  bit               hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  per_thread_cached_block_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_thread         (in_thread),
    .in_block          (in_block),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted_block (out_granted_block),
    .out_granted       (out_granted),
    .out_overflow      (out_overflow)
  );

  pcba_alloc_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_thread         (in_thread),
    .in_block          (in_block),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted_block (out_granted_block),
    .out_granted       (out_granted),
    .out_overflow      (out_overflow),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic offer_word(input logic [OP_W-1:0] op, input logic [THR_W-1:0] thr,
                            input logic [BLK_W-1:0] blk, input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_thread <= thr;
    in_block  <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    int       order [BLOCKS_DEF];
    int       j;
    int       k;
    int       tmp;
    int       seg_len;
    int       thr_lo;
    int       thr_span;
    int       n_random;
    int       pct;
    bit       no_gaps;
    req_mix_t mix;
    logic [OP_W-1:0] op;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_op     <= OP_ALLOC;
    in_thread <= '0;
    in_block  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_word(OP_ALLOC, 3'd0, 6'd0, 1'b0);     // both stacks empty: no grant
    offer_word(OP_FREE, 3'd7, 6'd63, 1'b0);
    offer_word(OP_ALLOC, 3'd7, 6'd0, 1'b0);
    offer_word(OP_FREE, 3'd0, 6'd0, 1'b0);
    offer_word(OP_ALLOC, 3'd0, 6'd63, 1'b0);    // block field ignored on allocate
    for (j = 1; j <= 7; j++)                    // seventh free spills three words
      offer_word(OP_FREE, 3'd3, BLK_W'(j), 1'b1);
    for (j = 0; j < 4; j++)                     // refill of three, then nothing left
      offer_word(OP_ALLOC, 3'd5, 6'd0, 1'b0);
    offer_word(OP_ALLOC, 3'd3, 6'd0, 1'b0);

    // prime: every block freed through thread 0, in shuffled order
    for (j = 0; j < BLOCKS_DEF; j++) order[j] = j;
    for (j = BLOCKS_DEF - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    for (j = 0; j < BLOCKS_DEF; j++) offer_word(OP_FREE, 3'd0, BLK_W'(order[j]), 1'b0);

    n_random = BLOCKS_DEF;
    while (n_random < RANDOM_WORDS) begin
      seg_len = $urandom_range(20, 80);
      mix     = req_mix_t'($urandom_range(0, 2));
      no_gaps = ($urandom_range(0, 3) == 0);
      // narrow thread sets make refills and spills on one stack frequent
      if ($urandom_range(0, 1)) begin
        thr_lo   = $urandom_range(0, 7);
        thr_span = $urandom_range(0, 1);
      end else begin
        thr_lo   = 0;
        thr_span = 7;
      end
      repeat (seg_len) begin
        pct = $urandom_range(0, 99);
        case (mix)
          MIX_ALLOC: op = (pct < 80) ? OP_ALLOC : OP_FREE;
          MIX_FREE:  op = (pct < 80) ? OP_FREE : OP_ALLOC;
          default:   op = (pct < 50) ? OP_ALLOC : OP_FREE;
        endcase
        offer_word(op, THR_W'(thr_lo + $urandom_range(0, thr_span)), BLK_W'($urandom),
                   no_gaps);
        n_random++;
        if (n_random == HOLD_AT) hold_req = 1'b1;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : result_side
    int n;
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off while requests keep coming
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  end

  initial begin : watchdog
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pcba_pkg.sv
src/pcba_ctrl.sv
src/pcba_dpath.sv
src/per_thread_cached_block_allocator.sv
bench/pcba_alloc_checker.sv
bench/tb_per_thread_cached_block_allocator.sv
